FILE: sv/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: sv/uto_pkg.sv
// Types, error codes and constants for the UTF-8 to modified UTF-8 transcoder
`timescale 1ns / 1ps

package uto_pkg;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_OVERLONG2 = 3'd1;
    localparam logic [2:0] ERR_BAD3      = 3'd2;
    localparam logic [2:0] ERR_OVERLONG4 = 3'd3;
    localparam logic [2:0] ERR_TRUNC     = 3'd4;
    localparam logic [2:0] ERR_START     = 3'd5;

    localparam logic [15:0] SURR_D800 = 16'hD800;
    localparam logic [15:0] SURR_DB7F = 16'hDB7F;
    localparam logic [15:0] SURR_DB80 = 16'hDB80;
    localparam logic [15:0] SURR_DBFF = 16'hDBFF;
    localparam logic [15:0] SURR_DC00 = 16'hDC00;
    localparam logic [15:0] SURR_DF80 = 16'hDF80;
    localparam logic [15:0] SURR_DFFF = 16'hDFFF;

    localparam logic [7:0] BYTE_ED   = 8'hED;
    localparam logic [7:0] BYTE_A0   = 8'hA0;
    localparam logic [7:0] BYTE_B0   = 8'hB0;
    localparam logic [7:0] BYTE_C0   = 8'hC0;
    localparam logic [7:0] BYTE_80   = 8'h80;
    localparam logic [15:0] MAX_2BYTE_POINT = 16'h07FF;

    localparam int MAX_OUT = 6;

    // One request for the back end: bytes go out from index 0 upward
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [2:0]              count;
        logic [2:0]              err;
        logic                    eos;
    } job_t;

    function automatic logic bad_point3(input logic [15:0] cp);
        logic bad;
        bad = (cp <= MAX_2BYTE_POINT) ||
              (cp == SURR_D800) || (cp == SURR_DB7F) || (cp == SURR_DB80) ||
              (cp == SURR_DBFF) || (cp == SURR_DC00) || (cp == SURR_DF80) ||
              (cp == SURR_DFFF);
        return bad;
    endfunction

endpackage

FILE: sv/uto_stream_if.sv
// Valid/ready stream interfaces for the transcoder input and output channels
`timescale 1ns / 1ps

interface uto_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface uto_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       string_done;
    logic [2:0] error_code;

    modport source (output valid, output out_byte, output last_of_run,
                    output string_done, output error_code, input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input string_done, input error_code, output ready);
endinterface

FILE: sv/uto_front.sv
// Front end: accepts input bytes, tracks sequence state, builds output requests
`timescale 1ns / 1ps

module uto_front (
    input  logic          clk,
    input  logic          rst_n,
    uto_in_if.sink        src,
    input  logic          q_ready,
    output logic          job_valid,
    output uto_pkg::job_t job
);
    import uto_pkg::*;

    logic [7:0] held_reg [3];
    logic [1:0] expected_reg, expected_next;
    logic [1:0] count_reg, count_next;
    logic       discard_reg, discard_next;

    logic       take;
    logic [7:0] b;
    logic       eos;
    logic       hold_en;
    logic       fail;
    logic [2:0] fail_code;
    logic [7:0] b1, b2, b3;
    logic [15:0] cp16;
    logic [4:0] plane;
    logic [4:0] plane_m1;

    assign src.ready = q_ready;
    assign take      = src.valid && src.ready;
    assign b         = src.in_byte;
    assign eos       = src.end_of_string;

    assign b1       = held_reg[0];
    assign b2       = (expected_reg >= 2'd2) ? held_reg[1] : b;
    assign b3       = (expected_reg >= 2'd3) ? held_reg[2] : b;
    assign cp16     = {b1[3:0], b2[5:0], b3[5:0]};
    assign plane    = {b1[2:0], b2[5:4]};
    assign plane_m1 = plane - 5'd1;

    always_comb
    begin
        expected_next = expected_reg;
        count_next    = count_reg;
        discard_next  = discard_reg;
        job_valid     = 1'b0;
        job           = '0;
        job.eos       = eos;
        hold_en       = 1'b0;
        fail          = 1'b0;
        fail_code     = ERR_NONE;

        if (take)
        begin
            if (discard_reg)
            begin
                if (eos)
                begin
                    discard_next = 1'b0;
                end
            end
            else if (count_reg == 2'd0)
            begin
                if (!b[7])
                begin
                    job_valid = 1'b1;
                    if (b != 8'h00)
                    begin
                        job.bytes[0] = b;
                        job.count    = 3'd1;
                    end
                    else
                    begin
                        job.bytes[0] = BYTE_C0;
                        job.bytes[1] = BYTE_80;
                        job.count    = 3'd2;
                    end
                end
                else if ((b[7:5] == 3'b110) || (b[7:4] == 4'b1110) || (b[7:3] == 5'b11110))
                begin
                    if (eos)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_TRUNC;
                    end
                    else
                    begin
                        hold_en    = 1'b1;
                        count_next = 2'd1;
                        if (b[7:5] == 3'b110)
                        begin
                            expected_next = 2'd1;
                        end
                        else if (b[7:4] == 4'b1110)
                        begin
                            expected_next = 2'd2;
                        end
                        else
                        begin
                            expected_next = 2'd3;
                        end
                    end
                end
                else
                begin
                    fail      = 1'b1;
                    fail_code = ERR_START;
                end
            end
            else if (count_reg < expected_reg)
            begin
                if (eos)
                begin
                    fail      = 1'b1;
                    fail_code = ERR_TRUNC;
                end
                else
                begin
                    hold_en    = 1'b1;
                    count_next = count_reg + 2'd1;
                end
            end
            else
            begin
                case (expected_reg)
                    2'd1:
                    begin
                        if (b1[4:1] == 4'd0)
                        begin
                            fail      = 1'b1;
                            fail_code = ERR_OVERLONG2;
                        end
                        else
                        begin
                            job.bytes[0] = b1;
                            job.bytes[1] = b2;
                            job.count    = 3'd2;
                        end
                    end
                    2'd2:
                    begin
                        if (bad_point3(cp16))
                        begin
                            fail      = 1'b1;
                            fail_code = ERR_BAD3;
                        end
                        else
                        begin
                            job.bytes[0] = b1;
                            job.bytes[1] = b2;
                            job.bytes[2] = b3;
                            job.count    = 3'd3;
                        end
                    end
                    default:
                    begin
                        if (plane == 5'd0)
                        begin
                            fail      = 1'b1;
                            fail_code = ERR_OVERLONG4;
                        end
                        else
                        begin
                            job.bytes[0] = BYTE_ED;
                            job.bytes[1] = BYTE_A0 + {4'd0, plane_m1[3:0]};
                            job.bytes[2] = BYTE_80 + {2'd0, b2[3:0], b3[5:4]};
                            job.bytes[3] = BYTE_ED;
                            job.bytes[4] = BYTE_B0 + {4'd0, b3[3:0]};
                            job.bytes[5] = b;
                            job.count    = 3'd6;
                        end
                    end
                endcase
                if (!fail)
                begin
                    job_valid     = 1'b1;
                    expected_next = 2'd0;
                    count_next    = 2'd0;
                end
            end

            if (fail)
            begin
                job_valid     = 1'b1;
                job.bytes     = '0;
                job.count     = 3'd1;
                job.err       = fail_code;
                expected_next = 2'd0;
                count_next    = 2'd0;
                discard_next  = !eos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg <= 2'd0;
            count_reg    <= 2'd0;
            discard_reg  <= 1'b0;
        end
        else
        begin
            expected_reg <= expected_next;
            count_reg    <= count_next;
            discard_reg  <= discard_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold_en)
        begin
            held_reg[count_reg] <= b;
        end
    end

endmodule

FILE: sv/uto_queue.sv
// Short request queue between the front end and the back end
`timescale 1ns / 1ps

module uto_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  uto_pkg::job_t push_data,
    output logic          not_full,
    input  logic          pop,
    output logic          pop_valid,
    output uto_pkg::job_t pop_data
);
    import uto_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push, do_pop;

    assign not_full  = (fill_reg != CNT_W'(DEPTH));
    assign pop_valid = (fill_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && not_full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/uto_back.sv
// Back end: one request byte per cycle into the output register when unstalled
`timescale 1ns / 1ps

module uto_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  uto_pkg::job_t q_data,
    output logic          q_pop,
    uto_out_if.source     dst
);
    import uto_pkg::*;

    job_t       cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_done_reg;
    logic [2:0] out_err_reg;
    logic       emit;
    logic       last;

    assign emit  = cur_valid_reg && (!out_valid_reg || dst.ready);
    assign last  = (cur_reg.count == 3'd1);
    assign q_pop = q_valid && (!cur_valid_reg || (emit && last));

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        if (q_pop)
        begin
            cur_next       = q_data;
            cur_valid_next = 1'b1;
        end
        else if (emit)
        begin
            if (last)
            begin
                cur_valid_next = 1'b0;
            end
            else
            begin
                cur_next.bytes = cur_reg.bytes >> 8;
                cur_next.count = cur_reg.count - 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (dst.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            out_byte_reg <= cur_reg.bytes[0];
            out_last_reg <= last;
            out_done_reg <= last && cur_reg.eos;
            out_err_reg  <= cur_reg.err;
        end
    end

    assign dst.valid       = out_valid_reg;
    assign dst.out_byte    = out_byte_reg;
    assign dst.last_of_run = out_last_reg;
    assign dst.string_done = out_done_reg;
    assign dst.error_code  = out_err_reg;

endmodule

FILE: sv/utf8_to_modified_utf8_transcoder_core.sv
// Top level of the UTF-8 to modified UTF-8 transcoder
// Path: results go via a queue entry, the current request and the output registers.
// Throughput: one result byte per cycle when not stalled; an input byte gives up to 6
// result bytes (2 for a zero byte), and some bytes give none.
// The output register, when not stalled, plays out one byte per cycle: the sustained rate.
// Reset: rst_n clears sequence state, queue and output valid; held bytes are not cleared.
`timescale 1ns / 1ps

module utf8_to_modified_utf8_transcoder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      clk,
    input  logic      rst_n,
    uto_in_if.sink    src,
    uto_out_if.source dst
);
    import uto_pkg::*;

    logic q_ready;
    logic job_valid;
    job_t job;
    logic q_valid;
    job_t q_data;
    logic q_pop;

    uto_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src       (src),
        .q_ready   (q_ready),
        .job_valid (job_valid),
        .job       (job)
    );

    uto_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_valid),
        .push_data (job),
        .not_full  (q_ready),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    uto_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .dst     (dst)
    );

endmodule

FILE: sv/uto_checker.sv
// Port checker for the transcoder top level, with its bind statement
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uto_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_last_of_run,
    input logic       out_string_done,
    input logic [2:0] out_error_code
);
    import uto_pkg::*;

    `ASSERT_IMPL(a_err_result_form, out_valid && (out_error_code != ERR_NONE), (out_byte == 8'h00) && out_last_of_run, "error result must be a zero byte ending its run")
    `ASSERT_IMPL(a_done_ends_run, out_valid && out_string_done, out_last_of_run, "string_done without last_of_run")
    `ASSERT_NEXT(a_valid_hold, out_valid && !out_ready, out_valid, "output valid dropped while stalled")
    `ASSERT_NEXT(a_stall_stable, out_valid && !out_ready, $stable(out_byte) && $stable(out_error_code), "output payload changed while stalled")

endmodule

bind utf8_to_modified_utf8_transcoder_core uto_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (dst.valid),
    .out_ready       (dst.ready),
    .out_byte        (dst.out_byte),
    .out_last_of_run (dst.last_of_run),
    .out_string_done (dst.string_done),
    .out_error_code  (dst.error_code)
);
